[design/pudsd_pkg.sv]
package pudsd_pkg;

    localparam int STREAK_W   = 16;
    localparam int WINDOW_W   = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [STREAK_W-1:0] STREAK_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DENY_THRESHOLD = 8'd1;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET    = 24'd60;
    localparam logic [STREAK_W-1:0] THRESHOLD_RESET = 16'd5;

    typedef struct packed {
        logic        authenticated;
        logic [7:0]  user_slot;
        logic        denied;
        logic [63:0] event_time;
    } in_item_t;

    typedef struct packed {
        logic [STREAK_W-1:0] streak_now;
        logic                anomaly_now;
        logic                anomaly_mark;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BUSY
    } state_t;

    typedef struct packed {
        logic capture;
        logic clr_write;
        logic update;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic out_free;
    } status_t;

endpackage

[design/pudsd_ram.sv]
module pudsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[design/pudsd_ctrl.sv]
module pudsd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pudsd_pkg::status_t status,
    output pudsd_pkg::cmd_t    cmd
);

    import pudsd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.capture   = 1'b0;
        cmd.clr_write = 1'b0;
        cmd.update    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_write = 1'b1;
                if (status.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_BUSY;
                end
            end
            ST_BUSY:
            begin
                if (status.out_free)
                begin
                    cmd.update = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

[design/pudsd_datapath.sv]
module pudsd_datapath #(
    parameter int USER_SLOTS = 256,
    parameter int STAMP_BITS = 24
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  pudsd_pkg::in_item_t                 in_item,
    output pudsd_pkg::out_item_t                out_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    input  logic                                cfg_valid,
    input  logic [pudsd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [pudsd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  pudsd_pkg::cmd_t                     cmd,
    output pudsd_pkg::status_t                  status
);

    import pudsd_pkg::*;

    localparam int SLOT_W = $clog2(USER_SLOTS);
    localparam int WORD_W = STAMP_BITS + STREAK_W + 2;
    localparam int CMP_W  = 32;

    localparam int STAMP_LO = STREAK_W;
    localparam int VALID_B  = STREAK_W + STAMP_BITS;
    localparam int FLAG_B   = VALID_B + 1;

    logic [WINDOW_W-1:0]   window_reg;
    logic [STREAK_W-1:0]   threshold_reg;

    logic [SLOT_W-1:0]     clr_addr_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [STAMP_BITS-1:0] stamp_reg;
    logic                  auth_reg;
    logic                  denied_reg;

    out_item_t             out_item_reg;
    logic                  out_valid_reg;

    logic [7:0]            slot_rem;
    logic [SLOT_W-1:0]     slot_in;
    logic [SLOT_W-1:0]     ram_addr;
    logic                  ram_we;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;

    logic                  hist;
    logic                  old_flag;
    logic [STREAK_W-1:0]   prev;
    logic [STAMP_BITS-1:0] hist_stamp;
    logic [STAMP_BITS-1:0] gap;
    logic                  in_window;
    logic [STREAK_W-1:0]   streak;
    logic                  now;
    out_item_t             result;

    // slot modulo USER_SLOTS by restoring subtraction
    always_comb
    begin
        slot_rem = in_item.user_slot;
        for (int k = 7; k >= 0; k--)
        begin
            if (CMP_W'(slot_rem) >= (CMP_W'(USER_SLOTS) << k))
            begin
                slot_rem = slot_rem - 8'(CMP_W'(USER_SLOTS) << k);
            end
        end
        slot_in = SLOT_W'(slot_rem);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= WINDOW_RESET;
            threshold_reg <= THRESHOLD_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_WINDOW_LIMIT)
            begin
                window_reg <= cfg_data[WINDOW_W-1:0];
            end
            else if (cfg_index == CFG_DENY_THRESHOLD)
            begin
                threshold_reg <= cfg_data[STREAK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr_write)
        begin
            clr_addr_reg <= clr_addr_reg + SLOT_W'(1);
        end
    end

    assign status.clear_done = (clr_addr_reg == SLOT_W'(USER_SLOTS - 1));
    assign status.out_free   = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            slot_reg   <= slot_in;
            stamp_reg  <= in_item.event_time[STAMP_BITS-1:0];
            auth_reg   <= in_item.authenticated;
            denied_reg <= in_item.denied;
        end
    end

    // streak update
    always_comb
    begin
        hist       = ram_rdata[VALID_B];
        old_flag   = ram_rdata[FLAG_B];
        prev       = hist ? ram_rdata[STREAK_W-1:0] : '0;
        hist_stamp = hist ? ram_rdata[STAMP_LO +: STAMP_BITS] : '0;
        gap        = stamp_reg - hist_stamp;
        in_window  = CMP_W'(gap) <= CMP_W'(window_reg);
        if (prev != '0 && in_window)
        begin
            streak = (prev == STREAK_MAX) ? STREAK_MAX : prev + STREAK_W'(1);
        end
        else
        begin
            streak = STREAK_W'(1);
        end
        now = streak >= threshold_reg;

        result = '0;
        if (auth_reg && denied_reg)
        begin
            result.streak_now   = streak;
            result.anomaly_now  = now;
            result.anomaly_mark = now || old_flag;
        end
    end

    always_comb
    begin
        ram_addr  = slot_reg;
        ram_we    = 1'b0;
        ram_wdata = '0;
        if (cmd.clr_write)
        begin
            ram_addr = clr_addr_reg;
            ram_we   = 1'b1;
        end
        else if (cmd.capture)
        begin
            ram_addr = slot_in;
        end
        else if (cmd.update && auth_reg)
        begin
            ram_we = 1'b1;
            if (denied_reg)
            begin
                ram_wdata = {result.anomaly_mark, 1'b1, stamp_reg, streak};
            end
        end
    end

    pudsd_ram #(
        .WIDTH (WORD_W),
        .DEPTH (USER_SLOTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .re    (cmd.capture),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            out_item_reg <= result;
        end
    end

    assign out_item  = out_item_reg;
    assign out_valid = out_valid_reg;

endmodule

[design/per_user_deny_streak_detector.sv]
// Table read is registered on input acceptance; the result enters the output register when it is free.
// Items are taken one at a time, set by the single table port (read, then write) for each item.
// A result waiting in the output register does not block acceptance of the next item.
// Reset: async active low; config returns to window 60, threshold 5, then a clearing
// pass zeroes every table entry before the first input is accepted.
module per_user_deny_streak_detector #(
    parameter int USER_SLOTS = 256,
    parameter int STAMP_BITS = 24
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  pudsd_pkg::in_item_t              in_item,
    output logic                             out_valid,
    input  logic                             out_ready,
    output pudsd_pkg::out_item_t             out_item,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pudsd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [pudsd_pkg::CFG_DATA_W-1:0] cfg_data
);

    import pudsd_pkg::*;

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    pudsd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pudsd_datapath #(
        .USER_SLOTS (USER_SLOTS),
        .STAMP_BITS (STAMP_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[test/tb_per_user_deny_streak_detector.sv]
`timescale 1ns / 1ps

module tb_per_user_deny_streak_detector;

    import pudsd_pkg::*;

    localparam int SLOTS      = 256;
    localparam int STAMP_W    = 24;
    localparam int SAT_EVENTS = 40;
    localparam int MAX_PRINTS = 20;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_item = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_item;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    per_user_deny_streak_detector uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // streak table copy
    logic                tbl_valid  [SLOTS];
    logic [STREAK_W-1:0] tbl_streak [SLOTS];
    logic [STAMP_W-1:0]  tbl_stamp  [SLOTS];
    logic                tbl_flag   [SLOTS];
    logic [WINDOW_W-1:0] window_lim;
    logic [STREAK_W-1:0] deny_thr;

    in_item_t  pending_events[$];
    out_item_t expected_results[$];

    int errors = 0;
    int events_accepted = 0;
    int results_checked = 0;
    int anomaly_hits = 0;
    int reg_writes = 0;

    logic [7:0]         hot_slots    [8];
    logic [STAMP_W-1:0] stamp_cursor [SLOTS];

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic out_item_t predict_deny_event(input in_item_t ev);
        logic [7:0]          s;
        logic [STAMP_W-1:0]  st;
        logic [STAMP_W-1:0]  gap;
        logic [STREAK_W-1:0] prev;
        logic [STREAK_W-1:0] streak;
        out_item_t           r;
        r = '0;
        s = ev.user_slot;
        st = ev.event_time[STAMP_W-1:0];
        if (ev.authenticated && !ev.denied)
        begin
            tbl_valid[s] = 1'b0;
            tbl_flag[s] = 1'b0;
        end
        else if (ev.authenticated)
        begin
            prev = tbl_valid[s] ? tbl_streak[s] : '0;
            gap = st - (tbl_valid[s] ? tbl_stamp[s] : '0);
            if (prev != 0 && gap <= window_lim)
                streak = (prev == STREAK_MAX) ? STREAK_MAX : prev + 1'b1;
            else
                streak = 1;
            tbl_valid[s] = 1'b1;
            tbl_streak[s] = streak;
            tbl_stamp[s] = st;
            if (streak >= deny_thr)
            begin
                tbl_flag[s] = 1'b1;
                r.anomaly_now = 1'b1;
            end
            r.anomaly_mark = tbl_flag[s];
            r.streak_now = streak;
        end
        return r;
    endfunction

    // driver: bursts of random length, random gaps between them
    int burst_left;
    int gap_left;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_item <= '0;
            burst_left = 1;
            gap_left = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (pending_events.size() > 0)
            begin
                in_item <= pending_events.pop_front();
                in_valid <= 1'b1;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // receiver stalls; stall style rotates through four modes as rx_cycle advances
    int stall_left;
    int rx_cycle;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
            rx_cycle = 0;
        end
        else
        begin
            rx_cycle++;
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 300) % 4)
                    0: out_ready <= 1'b1;
                    1:
                    begin
                        if ($urandom_range(0, 3) == 0)
                        begin
                            stall_left = $urandom_range(0, 2);
                            out_ready <= 1'b0;
                        end
                        else
                            out_ready <= 1'b1;
                    end
                    2:
                    begin
                        if ($urandom_range(0, 1) == 0)
                        begin
                            stall_left = $urandom_range(0, 9);
                            out_ready <= 1'b0;
                        end
                        else
                            out_ready <= 1'b1;
                    end
                    default: out_ready <= 1'($urandom_range(0, 1));
                endcase
            end
        end
    end

    // monitor: predicts on each input transaction, checks each result transaction
    always @(posedge clk or negedge rst_n)
    begin : monitor
        out_item_t want;
        if (!rst_n)
        begin
            window_lim = WINDOW_RESET;
            deny_thr = THRESHOLD_RESET;
            for (int i = 0; i < SLOTS; i++)
            begin
                tbl_valid[i] = 1'b0;
                tbl_flag[i] = 1'b0;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                case (cfg_index)
                    CFG_WINDOW_LIMIT:   window_lim = cfg_data[WINDOW_W-1:0];
                    CFG_DENY_THRESHOLD: deny_thr = cfg_data[STREAK_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                events_accepted++;
                expected_results.push_back(predict_deny_event(in_item));
            end
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch($sformatf("result with nothing expected: %p", out_item));
                else
                begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (want.anomaly_now)
                        anomaly_hits++;
                    if (out_item.streak_now !== want.streak_now)
                        report_mismatch($sformatf("streak_now %0d, expected %0d",
                            out_item.streak_now, want.streak_now));
                    if (out_item.anomaly_now !== want.anomaly_now)
                        report_mismatch($sformatf("anomaly_now %b, expected %b",
                            out_item.anomaly_now, want.anomaly_now));
                    if (out_item.anomaly_mark !== want.anomaly_mark)
                        report_mismatch($sformatf("anomaly_mark %b, expected %b",
                            out_item.anomaly_mark, want.anomaly_mark));
                end
            end
        end
    end

    function automatic in_item_t make_event(input logic auth, input logic [7:0] slot,
                                            input logic den, input logic [63:0] stamp);
        in_item_t ev;
        ev.authenticated = auth;
        ev.user_slot = slot;
        ev.denied = den;
        ev.event_time = stamp;
        return ev;
    endfunction

    task automatic wait_drained();
        @(negedge clk);
        while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [WINDOW_W-1:0] win, input logic [STREAK_W-1:0] thr);
        wait_drained();
        write_register(CFG_WINDOW_LIMIT, win);
        write_register(CFG_DENY_THRESHOLD, {{(CFG_DATA_W-STREAK_W){1'b0}}, thr});
        for (int i = 0; i < 8; i++)
            hot_slots[i] = 8'($urandom);
    endtask

    // mostly denial runs on a few hot users with gaps around the window
    task automatic queue_random_events(input int count);
        int         n;
        int         pick;
        logic [7:0] s;
        logic [31:0] gap;
        in_item_t   ev;
        n = 0;
        while (n < count)
        begin
            pick = $urandom_range(0, 99);
            s = (pick < 80) ? hot_slots[$urandom_range(0, 7)] : 8'($urandom);
            ev = make_event(1'b1, s, 1'b1, {$urandom, $urandom});
            if (pick >= 95)
            begin
                ev.authenticated = 1'b0;
                ev.denied = 1'($urandom_range(0, 1));
            end
            else
            begin
                n++;
                if ($urandom_range(0, 9) == 0)
                    ev.denied = 1'b0;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: gap = $urandom_range(0, window_lim);
                    6: gap = window_lim;
                    7: gap = window_lim + 1;
                    8: gap = $urandom;
                    default: gap = 0;
                endcase
                stamp_cursor[s] = stamp_cursor[s] + gap[STAMP_W-1:0];
                ev.event_time[STAMP_W-1:0] = stamp_cursor[s];
            end
            pending_events.push_back(ev);
        end
    endtask

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
            stamp_cursor[i] = 24'($urandom);
        for (int i = 0; i < 8; i++)
            hot_slots[i] = 8'($urandom);
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: window 60, threshold 5
        pending_events.push_back(make_event(1'b0, 8'd255, 1'b1, '1));
        pending_events.push_back(make_event(1'b0, 8'd0, 1'b0, '0));
        pending_events.push_back(make_event(1'b1, 8'd255, 1'b0, 64'h8000_0000_0000_0000));
        for (int i = 0; i < 5; i++)
            pending_events.push_back(make_event(1'b1, 8'd3, 1'b1, 64'(100 + 10 * i)));
        pending_events.push_back(make_event(1'b1, 8'd3, 1'b1, 64'd200));
        pending_events.push_back(make_event(1'b1, 8'd3, 1'b1, 64'd261));
        pending_events.push_back(make_event(1'b0, 8'd3, 1'b0, 64'd261));
        pending_events.push_back(make_event(1'b1, 8'd3, 1'b1, 64'd261));
        pending_events.push_back(make_event(1'b1, 8'd3, 1'b0, 64'd280));
        pending_events.push_back(make_event(1'b1, 8'd3, 1'b1, 64'd300));
        pending_events.push_back(make_event(1'b1, 8'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FFF0));
        pending_events.push_back(make_event(1'b1, 8'd0, 1'b1, 64'h0000_0000_0000_0010));
        pending_events.push_back(make_event(1'b1, 8'd128, 1'b1, 64'h5555_5555_5555_5555));
        pending_events.push_back(make_event(1'b1, 8'd128, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA));

        set_config('0, 16'd1);
        queue_random_events(200);

        // widest window, top threshold: one user builds a long unbroken streak
        set_config('1, STREAK_MAX);
        for (int i = 0; i < SAT_EVENTS; i++)
            pending_events.push_back(make_event(1'b1, 8'd77, 1'b1,
                {$urandom, 8'($urandom), 24'(i * 7)}));
        queue_random_events(100);

        set_config('0, 16'd0);
        queue_random_events(100);

        repeat (4)
        begin
            set_config(($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(1, 120)),
                       ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(2, 8)));
            queue_random_events(200);
        end

        set_config(WINDOW_RESET, THRESHOLD_RESET);
        queue_random_events(100);

        wait_drained();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        $display("run: %0d events in, %0d results checked, %0d anomalies, %0d register writes",
                 events_accepted, results_checked, anomaly_hits, reg_writes);
        $display("run: window 0..max, threshold 0..65535, long single-user streak, stamp wrap");
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
